// ===== rtl/fla_pkg.sv =====
`default_nettype none
package fla_pkg;

    localparam int MAX_FREE_BLOCKS = 16;
    localparam int IDX_W = $clog2(MAX_FREE_BLOCKS);
    localparam int CNT_W = $clog2(MAX_FREE_BLOCKS + 1);
    localparam int HEADER_BYTES = 16;
    localparam logic [20:0] POOL_CAP = 21'd1048576;
    localparam logic [20:0] POOL_RESET = 21'd65536;

    localparam logic [1:0] CMD_ALLOC = 2'd0;
    localparam logic [1:0] CMD_RELEASE = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_OOM = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;
    localparam logic [1:0] ST_BAD = 2'd3;

    localparam logic [0:0] REG_FIT_POLICY = 1'd0;
    localparam logic [0:0] REG_POOL_BYTES = 1'd1;

    typedef struct packed {
        logic [1:0]  command;
        logic [20:0] request_bytes;
        logic [3:0]  align_log2;
        logic [19:0] block_start;
        logic [20:0] block_length;
    } in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [19:0] payload_offset;
        logic [19:0] granted_start;
        logic [20:0] granted_length;
        logic [20:0] bytes_in_use;
        logic [8:0]  free_block_count;
    } out_t;

    typedef struct packed {
        logic             clr;
        logic [20:0]      clr_len;
        logic             wr_en;
        logic [IDX_W-1:0] wr_idx;
        logic [20:0]      wr_start;
        logic [20:0]      wr_len;
        logic             sh_up;
        logic             sh_dn;
        logic [IDX_W-1:0] sh_idx;
    } cell_op_t;

endpackage
`default_nettype wire

// ===== rtl/fla_cell.sv =====
`default_nettype none
module fla_cell (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic [fla_pkg::IDX_W-1:0]    idx,
    input  wire fla_pkg::cell_op_t            op,
    input  wire logic [20:0]                  lo_start,
    input  wire logic [20:0]                  lo_len,
    input  wire logic [20:0]                  hi_start,
    input  wire logic [20:0]                  hi_len,
    output logic [20:0]                       start,
    output logic [20:0]                       len
);

    logic [20:0] start_reg, start_next;
    logic [20:0] len_reg, len_next;

    always_comb
    begin
        start_next = start_reg;
        len_next = len_reg;
        if (op.clr)
        begin
            start_next = '0;
            len_next = (idx == '0) ? op.clr_len : '0;
        end
        else if (op.wr_en && op.wr_idx == idx)
        begin
            start_next = op.wr_start;
            len_next = op.wr_len;
        end
        else if (op.sh_dn && idx >= op.sh_idx)
        begin
            start_next = hi_start;
            len_next = hi_len;
        end
        else if (op.sh_up && idx > op.sh_idx)
        begin
            start_next = lo_start;
            len_next = lo_len;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= '0;
            len_reg <= (idx == '0) ? fla_pkg::POOL_RESET : '0;
        end
        else
        begin
            start_reg <= start_next;
            len_reg <= len_next;
        end
    end

    assign start = start_reg;
    assign len = len_reg;

endmodule
`default_nettype wire

// ===== rtl/fla_ctrl.sv =====
`default_nettype none
module fla_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire fla_pkg::in_t  request,
    output logic               done,
    output fla_pkg::out_t      result,
    input  wire logic          fit_policy,
    input  wire logic [20:0]   pool_bytes,
    input  wire logic [fla_pkg::MAX_FREE_BLOCKS-1:0][20:0] tbl_start,
    input  wire logic [fla_pkg::MAX_FREE_BLOCKS-1:0][20:0] tbl_len,
    output fla_pkg::cell_op_t  op
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DECIDE = 2'd2;

    logic [1:0] state_reg, state_next;
    fla_pkg::in_t req_reg, req_next;
    logic pre_bad_reg, pre_bad_next;
    logic [fla_pkg::CNT_W-1:0] idx_reg, idx_next;
    logic [fla_pkg::CNT_W-1:0] count_reg, count_next;
    logic [20:0] used_reg, used_next;
    logic [20:0] limit_reg, limit_next;
    logic found_reg, found_next;
    logic [fla_pkg::IDX_W-1:0] best_reg, best_next;
    logic [12:0] pad_reg, pad_next;
    logic [20:0] bstart_reg, bstart_next;
    logic [20:0] blen_reg, blen_next;
    logic overlap_reg, overlap_next;
    logic [fla_pkg::CNT_W-1:0] pos_reg, pos_next;
    logic has_next_reg, has_next_next;
    logic [20:0] nstart_reg, nstart_next;
    logic [20:0] nlen_reg, nlen_next;
    logic done_reg, done_next;
    fla_pkg::out_t res_reg, res_next;

    logic [20:0] es, el;
    logic [12:0] align_m1;
    logic [21:0] pad_sum, pad_aligned;
    logic [12:0] pad;
    logic [22:0] need_w;
    logic fits;
    logic [21:0] rel_end, ent_end, prev_end;
    logic [20:0] need, rest, psat;
    logic jp, jn;

    always_comb
    begin
        es = tbl_start[idx_reg[fla_pkg::IDX_W-1:0]];
        el = tbl_len[idx_reg[fla_pkg::IDX_W-1:0]];
        align_m1 = 13'((14'd1 << req_reg.align_log2) - 14'd1);
        pad_sum = {1'b0, es} + 22'(fla_pkg::HEADER_BYTES) + {9'd0, align_m1};
        pad_aligned = pad_sum & ~{9'd0, align_m1};
        pad = 13'(pad_aligned - {1'b0, es});
        need_w = {10'd0, pad} + {2'b0, req_reg.request_bytes};
        fits = {2'b0, el} >= need_w;
        rel_end = {2'b0, req_reg.block_start} + {1'b0, req_reg.block_length};
        ent_end = {1'b0, es} + {1'b0, el};
        prev_end = {1'b0, bstart_reg} + {1'b0, blen_reg};
        need = 21'({8'd0, pad_reg} + req_reg.request_bytes);
        rest = blen_reg - need;
        psat = (pool_bytes > fla_pkg::POOL_CAP) ? fla_pkg::POOL_CAP : pool_bytes;
        jp = (pos_reg != '0) && (prev_end == {2'b0, req_reg.block_start});
        jn = has_next_reg && ({1'b0, nstart_reg} == rel_end);
    end

    always_comb
    begin
        state_next = state_reg;
        req_next = req_reg;
        pre_bad_next = pre_bad_reg;
        idx_next = idx_reg;
        count_next = count_reg;
        used_next = used_reg;
        limit_next = limit_reg;
        found_next = found_reg;
        best_next = best_reg;
        pad_next = pad_reg;
        bstart_next = bstart_reg;
        blen_next = blen_reg;
        overlap_next = overlap_reg;
        pos_next = pos_reg;
        has_next_next = has_next_reg;
        nstart_next = nstart_reg;
        nlen_next = nlen_reg;
        done_next = 1'b0;
        res_next = res_reg;
        op = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    req_next = request;
                    idx_next = '0;
                    found_next = 1'b0;
                    overlap_next = 1'b0;
                    pos_next = '0;
                    has_next_next = 1'b0;
                    unique case (request.command)
                        fla_pkg::CMD_ALLOC:
                        begin
                            pre_bad_next = request.request_bytes == '0
                                || request.request_bytes > fla_pkg::POOL_CAP
                                || request.align_log2 < 4'd4 || request.align_log2 > 4'd12;
                            state_next = pre_bad_next ? S_DECIDE : S_SCAN;
                        end
                        fla_pkg::CMD_RELEASE:
                        begin
                            pre_bad_next = request.block_length == '0
                                || ({2'b0, request.block_start} + {1'b0, request.block_length})
                                   > {1'b0, limit_reg};
                            state_next = pre_bad_next ? S_DECIDE : S_SCAN;
                        end
                        default:
                        begin
                            pre_bad_next = 1'b0;
                            state_next = S_DECIDE;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (idx_reg == count_reg)
                begin
                    state_next = S_DECIDE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                    if (req_reg.command == fla_pkg::CMD_ALLOC)
                    begin
                        if (fits && (!found_reg || (fit_policy && el < blen_reg)))
                        begin
                            found_next = 1'b1;
                            best_next = idx_reg[fla_pkg::IDX_W-1:0];
                            pad_next = pad;
                            bstart_next = es;
                            blen_next = el;
                        end
                        if (fits && !fit_policy)
                        begin
                            state_next = S_DECIDE;
                        end
                    end
                    else
                    begin
                        if ({1'b0, req_reg.block_start} < ent_end[20:0] && ent_end[21] == 1'b0
                            || {2'b0, req_reg.block_start} < ent_end && {1'b0, es} < rel_end)
                        begin
                            overlap_next = ({2'b0, req_reg.block_start} < ent_end)
                                && ({1'b0, es} < rel_end) || overlap_reg;
                        end
                        if (es < {1'b0, req_reg.block_start})
                        begin
                            pos_next = idx_reg + 1'b1;
                            bstart_next = es;
                            blen_next = el;
                        end
                        else if (!has_next_reg)
                        begin
                            has_next_next = 1'b1;
                            nstart_next = es;
                            nlen_next = el;
                        end
                    end
                end
            end
            S_DECIDE:
            begin
                state_next = S_IDLE;
                done_next = 1'b1;
                res_next = '0;
                res_next.status = fla_pkg::ST_OK;
                if (pre_bad_reg)
                begin
                    res_next.status = fla_pkg::ST_BAD;
                end
                else
                begin
                    unique case (req_reg.command)
                        fla_pkg::CMD_ALLOC:
                        begin
                            if (!found_reg)
                            begin
                                res_next.status = fla_pkg::ST_OOM;
                            end
                            else
                            begin
                                res_next.payload_offset = 20'(bstart_reg + {8'd0, pad_reg});
                                res_next.granted_start = bstart_reg[19:0];
                                res_next.granted_length = need;
                                used_next = used_reg + need;
                                if (rest != '0)
                                begin
                                    op.wr_en = 1'b1;
                                    op.wr_idx = best_reg;
                                    op.wr_start = bstart_reg + need;
                                    op.wr_len = rest;
                                end
                                else
                                begin
                                    op.sh_dn = 1'b1;
                                    op.sh_idx = best_reg;
                                    count_next = count_reg - 1'b1;
                                end
                            end
                        end
                        fla_pkg::CMD_RELEASE:
                        begin
                            if (overlap_reg)
                            begin
                                res_next.status = fla_pkg::ST_BAD;
                            end
                            else if (!jp && !jn && count_reg >= fla_pkg::CNT_W'(fla_pkg::MAX_FREE_BLOCKS))
                            begin
                                res_next.status = fla_pkg::ST_FULL;
                            end
                            else
                            begin
                                used_next = (used_reg >= req_reg.block_length)
                                    ? used_reg - req_reg.block_length : '0;
                                if (jp)
                                begin
                                    op.wr_en = 1'b1;
                                    op.wr_idx = fla_pkg::IDX_W'(pos_reg - 1'b1);
                                    op.wr_start = bstart_reg;
                                    op.wr_len = blen_reg + req_reg.block_length
                                        + (jn ? nlen_reg : 21'd0);
                                    if (jn)
                                    begin
                                        op.sh_dn = 1'b1;
                                        op.sh_idx = pos_reg[fla_pkg::IDX_W-1:0];
                                        count_next = count_reg - 1'b1;
                                    end
                                end
                                else
                                begin
                                    op.wr_en = 1'b1;
                                    op.wr_idx = pos_reg[fla_pkg::IDX_W-1:0];
                                    op.wr_start = {1'b0, req_reg.block_start};
                                    op.wr_len = req_reg.block_length + (jn ? nlen_reg : 21'd0);
                                    if (!jn)
                                    begin
                                        op.sh_up = 1'b1;
                                        op.sh_idx = pos_reg[fla_pkg::IDX_W-1:0];
                                        count_next = count_reg + 1'b1;
                                    end
                                end
                            end
                        end
                        fla_pkg::CMD_CLEAR:
                        begin
                            op.clr = 1'b1;
                            op.clr_len = psat;
                            limit_next = psat;
                            used_next = '0;
                            count_next = (psat == '0) ? '0 : fla_pkg::CNT_W'(1);
                        end
                        default:
                        begin
                            res_next.status = fla_pkg::ST_BAD;
                        end
                    endcase
                end
                res_next.bytes_in_use = used_next;
                res_next.free_block_count = 9'(count_next);
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= fla_pkg::CNT_W'(1);
            used_reg <= '0;
            limit_reg <= fla_pkg::POOL_RESET;
            done_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            used_reg <= used_next;
            limit_reg <= limit_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        pre_bad_reg <= pre_bad_next;
        idx_reg <= idx_next;
        found_reg <= found_next;
        best_reg <= best_next;
        pad_reg <= pad_next;
        bstart_reg <= bstart_next;
        blen_reg <= blen_next;
        overlap_reg <= overlap_next;
        pos_reg <= pos_next;
        has_next_reg <= has_next_next;
        nstart_reg <= nstart_next;
        nlen_reg <= nlen_next;
        res_reg <= res_next;
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign result = res_reg;

endmodule
`default_nettype wire

// ===== rtl/free_list_allocator.sv =====
`default_nettype none
// Free-list allocator over a byte pool of up to 1 MiB.
// A command request (allocate, release, clear) is taken at a rising edge where
// start is high and busy is low. busy stays high until the result is out.
// The result appears on result as done goes high for exactly one cycle; the
// receiver cannot hold it off, so it must take it in that cycle.
// An allocate or release walks the free table one entry per cycle, up to the
// 16 entries of a full table; first fit stops early. A clear or a rejected
// request skips the walk.
// The free table is a row of cells; an insert or remove shifts the cells after
// the affected slot by one place toward their neighbor, all at the same clock edge.
// Registers on the APB port: fit_policy at 0x0 (0 first fit, 1 best fit) and
// pool_bytes at 0x4. A new pool size takes effect at the next clear.
// After reset the pool is 64 KiB, held as one free block at offset 0, with
// first fit selected and no bytes in use.
module free_list_allocator (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire fla_pkg::in_t  request,
    output logic               done,
    output fla_pkg::out_t      result,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [2:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic fit_reg, fit_next;
    logic [20:0] pool_reg, pool_next;
    logic wr;
    fla_pkg::cell_op_t op;
    logic [fla_pkg::MAX_FREE_BLOCKS-1:0][20:0] tbl_start;
    logic [fla_pkg::MAX_FREE_BLOCKS-1:0][20:0] tbl_len;

    assign pready = 1'b1;
    assign wr = psel && penable && pwrite;

    always_comb
    begin
        fit_next = fit_reg;
        pool_next = pool_reg;
        if (wr)
        begin
            unique case (paddr[2:2])
                fla_pkg::REG_FIT_POLICY: fit_next = pwdata[0];
                fla_pkg::REG_POOL_BYTES: pool_next = pwdata[20:0];
                default: fit_next = fit_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2:2])
            fla_pkg::REG_FIT_POLICY: prdata = {31'd0, fit_reg};
            fla_pkg::REG_POOL_BYTES: prdata = {11'd0, pool_reg};
            default: prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fit_reg <= 1'b0;
            pool_reg <= fla_pkg::POOL_RESET;
        end
        else
        begin
            fit_reg <= fit_next;
            pool_reg <= pool_next;
        end
    end

    fla_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .request    (request),
        .done       (done),
        .result     (result),
        .fit_policy (fit_reg),
        .pool_bytes (pool_reg),
        .tbl_start  (tbl_start),
        .tbl_len    (tbl_len),
        .op         (op)
    );

    for (genvar k = 0; k < fla_pkg::MAX_FREE_BLOCKS; k++)
    begin : g_cell
        logic [20:0] lo_s, lo_l, hi_s, hi_l;
        if (k == 0)
        begin : g_lo0
            assign lo_s = '0;
            assign lo_l = '0;
        end
        else
        begin : g_lo
            assign lo_s = tbl_start[k-1];
            assign lo_l = tbl_len[k-1];
        end
        if (k == fla_pkg::MAX_FREE_BLOCKS - 1)
        begin : g_hiN
            assign hi_s = '0;
            assign hi_l = '0;
        end
        else
        begin : g_hi
            assign hi_s = tbl_start[k+1];
            assign hi_l = tbl_len[k+1];
        end
        fla_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .idx      (fla_pkg::IDX_W'(k)),
            .op       (op),
            .lo_start (lo_s),
            .lo_len   (lo_l),
            .hi_start (hi_s),
            .hi_len   (hi_l),
            .start    (tbl_start[k]),
            .len      (tbl_len[k])
        );
    end

endmodule
`default_nettype wire
